FILE: rtl/mm4_pkg.sv
// Shared types and constants for the 4x4 fixed-point matrix multiplier.
// Used by mm4_col_sum and matrix_multiply_4x4; depends on nothing else.
`default_nettype none

package mm4_pkg;

  // Fraction bits of the signed fixed-point format (Q16.16 by default).
  localparam int unsigned FRAC_BITS = 16;

  localparam int unsigned ELEM_W = 32;
  localparam int unsigned PROD_W = 2 * ELEM_W;
  // Exact sum of four full-width products needs two more bits.
  localparam int unsigned ACC_W  = PROD_W + 2;
  localparam int unsigned DIM    = 4;
  localparam int unsigned ROW_W  = 2;

  localparam logic signed [ELEM_W-1:0] SAT_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
  localparam logic signed [ELEM_W-1:0] SAT_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

  typedef enum logic [0:0] {
    CMD_LOAD = 1'b0,
    CMD_MUL  = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e                     cmd;
    logic [ROW_W-1:0]         row_index;
    logic signed [ELEM_W-1:0] elem0;
    logic signed [ELEM_W-1:0] elem1;
    logic signed [ELEM_W-1:0] elem2;
    logic signed [ELEM_W-1:0] elem3;
  } in_item_t;

  typedef struct packed {
    logic [ROW_W-1:0]         out_row;
    logic signed [ELEM_W-1:0] prod0;
    logic signed [ELEM_W-1:0] prod1;
    logic signed [ELEM_W-1:0] prod2;
    logic signed [ELEM_W-1:0] prod3;
    logic                     clipped;
  } out_item_t;

endpackage

`default_nettype wire

FILE: rtl/mm4_col_sum.sv
// One column of a product row: sums four products, rescales and saturates.
// Depends on mm4_pkg.
`default_nettype none

module mm4_col_sum
  import mm4_pkg::*;
(
  input  logic signed [PROD_W-1:0] prod0_i,
  input  logic signed [PROD_W-1:0] prod1_i,
  input  logic signed [PROD_W-1:0] prod2_i,
  input  logic signed [PROD_W-1:0] prod3_i,
  output logic signed [ELEM_W-1:0] result_o,
  output logic                     sat_o
);

  logic signed [ACC_W-1:0] sum;
  logic signed [ACC_W-1:0] scaled;
  logic                    in_range;

  // The shift floors toward minus infinity, matching an arithmetic shift.
  assign sum = ACC_W'(prod0_i) + ACC_W'(prod1_i) + ACC_W'(prod2_i) + ACC_W'(prod3_i);
  assign scaled = sum >>> FRAC_BITS;

  // In range when every bit above the result's sign bit copies the sign.
  assign in_range = (&scaled[ACC_W-1:ELEM_W-1]) || !(|scaled[ACC_W-1:ELEM_W-1]);

  always_comb begin
    if (in_range) begin
      result_o = scaled[ELEM_W-1:0];
    end else if (sum[ACC_W-1]) begin
      result_o = SAT_MIN;
    end else begin
      result_o = SAT_MAX;
    end
  end

  assign sat_o = !in_range;

endmodule

`default_nettype wire

FILE: rtl/matrix_multiply_4x4.sv
// Top level of the 4x4 signed fixed-point matrix multiplier, C = A x B.
// Depends on mm4_pkg and mm4_col_sum.
// A multiply transfer moves through the input, product and result registers in turn.
// One item per cycle unless output stalls; sixteen 32x32 multipliers in parallel.
// Load transfers write a row of B at the accepting edge and give no result.
// Reset (rst_ni low, asynchronous) empties the pipeline and clears B to zero.
`default_nettype none

module matrix_multiply_4x4
  import mm4_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  // The pipeline has three registered stages: the input register holding a row
  // of A, the product register holding all sixteen products, and the result
  // register. Each stage advances when it is empty or the stage after it is
  // moving, so bubbles are squeezed out while a result waits at the output.

  logic signed [ELEM_W-1:0] b_q [DIM][DIM];

  logic                     s1_valid_q;
  logic [ROW_W-1:0]         s1_row_q;
  logic signed [ELEM_W-1:0] s1_a_q [DIM];

  logic                     s2_valid_q;
  logic [ROW_W-1:0]         s2_row_q;
  logic signed [PROD_W-1:0] s2_prod_q [DIM][DIM];

  logic                     out_valid_q;
  out_item_t                out_data_q;

  logic s1_ready, s2_ready, s3_ready;
  logic in_xfer, load_xfer, mul_xfer;

  logic signed [ELEM_W-1:0] in_a [DIM];
  logic signed [ELEM_W-1:0] col_res [DIM];
  logic [DIM-1:0]           col_sat;

  assign s3_ready = !out_valid_q || out_ready_i;
  assign s2_ready = !s2_valid_q || s3_ready;
  assign s1_ready = !s1_valid_q || s2_ready;

  assign in_ready_o = s1_ready;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign load_xfer  = in_xfer && (in_data_i.cmd == CMD_LOAD);
  assign mul_xfer   = in_xfer && (in_data_i.cmd == CMD_MUL);

  assign in_a[0] = in_data_i.elem0;
  assign in_a[1] = in_data_i.elem1;
  assign in_a[2] = in_data_i.elem2;
  assign in_a[3] = in_data_i.elem3;

  // Right matrix. A load writes at its accepting edge; a multiply in the input
  // register reads B on the same edge it moves on, so it sees every earlier
  // load and none of the later ones.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < DIM; r++) begin
        for (int c = 0; c < DIM; c++) begin
          b_q[r][c] <= '0;
        end
      end
    end else if (load_xfer) begin
      for (int c = 0; c < DIM; c++) begin
        b_q[in_data_i.row_index][c] <= in_a[c];
      end
    end
  end

  // Input register: only multiply transfers occupy it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= mul_xfer;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_xfer) begin
      s1_row_q <= in_data_i.row_index;
      for (int k = 0; k < DIM; k++) begin
        s1_a_q[k] <= in_a[k];
      end
    end
  end

  // Product register: A[k] * B[k][j] for every k and j.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      s2_row_q <= s1_row_q;
      for (int k = 0; k < DIM; k++) begin
        for (int j = 0; j < DIM; j++) begin
          s2_prod_q[k][j] <= s1_a_q[k] * b_q[k][j];
        end
      end
    end
  end

  // Column sums, rescaling and saturation.
  for (genvar j = 0; j < DIM; j++) begin : g_col
    mm4_col_sum u_col_sum (
      .prod0_i  (s2_prod_q[0][j]),
      .prod1_i  (s2_prod_q[1][j]),
      .prod2_i  (s2_prod_q[2][j]),
      .prod3_i  (s2_prod_q[3][j]),
      .result_o (col_res[j]),
      .sat_o    (col_sat[j])
    );
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s3_ready) begin
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_ready && s2_valid_q) begin
      out_data_q.out_row <= s2_row_q;
      out_data_q.prod0   <= col_res[0];
      out_data_q.prod1   <= col_res[1];
      out_data_q.prod2   <= col_res[2];
      out_data_q.prod3   <= col_res[3];
      out_data_q.clipped <= |col_sat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // A load never occupies the input register.
  a_load_no_slot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_xfer |=> !s1_valid_q)
    else $error("load transfer filled the input register");

  // A multiply lands in the input register with its row index.
  a_mul_captured : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_xfer |=> (s1_valid_q && s1_row_q == $past(in_data_i.row_index)))
    else $error("multiply transfer not captured");

  // A stalled product stage keeps its item.
  a_s2_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && !s3_ready) |=> (s2_valid_q && $stable(s2_row_q)))
    else $error("product stage lost an item under stall");

  // A clipped row carries at least one value at a saturation limit.
  a_clip_limit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.clipped) |->
      (out_data_o.prod0 == SAT_MAX || out_data_o.prod0 == SAT_MIN ||
       out_data_o.prod1 == SAT_MAX || out_data_o.prod1 == SAT_MIN ||
       out_data_o.prod2 == SAT_MAX || out_data_o.prod2 == SAT_MIN ||
       out_data_o.prod3 == SAT_MAX || out_data_o.prod3 == SAT_MIN))
    else $error("clipped flag without a saturated value");

endmodule

`default_nettype wire
